### rtl/membership_frame_checker_defines.svh
// Assertion macros for the membership frame checker.
`ifndef MEMBERSHIP_FRAME_CHECKER_DEFINES_SVH
`define MEMBERSHIP_FRAME_CHECKER_DEFINES_SVH

// Condition and consequence in the same cycle.
`define MFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence in the cycle after the condition.
`define MFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mfc_pkg.sv
// Shared types, constants and functions for the membership frame checker.
package mfc_pkg;

   localparam int DEF_MAX_VOTERS = 16;
   localparam int POS_W = 20;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [4:0] LIMIT_RESET = 5'd16;

   localparam logic RK_VOTER = 1'b0;
   localparam logic RK_VERDICT = 1'b1;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_CRC = 3'd2;
   localparam logic [2:0] ST_MAGIC = 3'd3;
   localparam logic [2:0] ST_MINOR = 3'd4;
   localparam logic [2:0] ST_HEADER = 3'd5;
   localparam logic [2:0] ST_SEMANTIC = 3'd6;

   localparam logic [15:0] VER_MAJOR = 16'd1;
   localparam logic [15:0] VER_MINOR = 16'd0;
   localparam logic [7:0] KIND_JOINT = 8'd1;
   localparam logic [7:0] KIND_FINAL = 8'd2;

   typedef logic [7:0] magic_type [8];
   localparam magic_type FRAME_MAGIC = '{8'h43, 8'h48, 8'h52, 8'h4E,
                                         8'h4D, 8'h42, 8'h43, 8'h00};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [63:0] voter_id;
      logic        voter_list;
      logic [2:0]  status;
      logic [7:0]  command_kind;
      logic [63:0] joint_log_index;
      logic [15:0] old_list_count;
      logic [15:0] new_list_count;
   } rsp_payload_type;

   typedef struct packed {
      logic step;
      logic mread;
      logic mcmp;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_merge;
      logic has_result;
      logic merge_again;
      logic out_free;
   } sts_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/mfc_ctrl.sv
// Sequencer: byte step, old-list merge walk and result hand-off.
module mfc_ctrl
   import mfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MREAD = 4'b0010,
      S_MCMP  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               if (sts.need_merge) state_in = S_MREAD;
               else if (sts.has_result) state_in = S_EMIT;
            end
         end
         S_MREAD: begin
            cmd.mread = 1'b1;
            state_in = S_MCMP;
         end
         S_MCMP: begin
            cmd.mcmp = 1'b1;
            state_in = sts.merge_again ? S_MREAD : S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

### rtl/mfc_datapath.sv
// Frame state, checksum, old voter store, verdict logic and output register.
module mfc_datapath
   import mfc_pkg::*;
#(
   parameter int MAX_VOTERS = DEF_MAX_VOTERS
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_data,
   input  logic            csr_we,
   input  logic [4:0]      csr_wdata,
   input  cmd_type         cmd,
   output sts_type         sts,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int IDX_W = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
   localparam int PTR_W = $clog2(MAX_VOTERS + 1);

   logic [4:0]       limit_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             magic_ok_ff, magic_ok_in;
   logic [63:0]      h1_ff, h1_in;
   logic [31:0]      h2_ff, h2_in;
   logic [63:0]      h3_ff, h3_in;
   logic [31:0]      h4_ff, h4_in;
   logic [63:0]      asm_ff, asm_in;
   logic [63:0]      prev_ff, prev_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [5:0]       union_ff, union_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      td_ff, td_in;
   logic [1:0]       lflags_ff, lflags_in;
   logic             sat_ff, sat_in;
   logic             fin_ff, fin_in;
   logic             list_ff, list_in;
   logic [63:0]      rd_ff;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_data_ff;

   logic [63:0]      store_mem [MAX_VOTERS];

   logic [7:0]       b;
   logic             sat;
   logic [15:0]      oldc, newc;
   logic [16:0]      total;
   logic [POS_W-1:0] rel;
   logic             region;
   logic [16:0]      k;
   logic             is_old;
   logic [63:0]      v;
   logic             voter_done;
   logic             mem_we;
   logic [PTR_W-1:0] bound;
   logic             ptr_lt;
   logic [15:0]      lim;
   logic [31:0]      len;
   logic [2:0]       verdict;
   logic             bad;
   rsp_payload_type  out_item;

   assign b = req_data.data_byte;
   assign sat = (pos_ff == POS_MAX);
   assign oldc = h4_ff[15:0];
   assign newc = h4_ff[31:16];
   assign total = 17'(oldc) + 17'(newc);
   assign rel = pos_ff - POS_W'(32);
   assign region = (pos_ff >= POS_W'(32)) && ({1'b0, rel} < {1'b0, total, 3'b000});
   assign k = rel[POS_W-1:3];
   assign is_old = k < {1'b0, oldc};
   assign v = {b, asm_ff[55:0]};
   assign voter_done = !sat && region && (rel[2:0] == 3'd7);
   assign mem_we = cmd.step && voter_done && is_old && (k < 17'(MAX_VOTERS));
   assign bound = (oldc < 16'(MAX_VOTERS)) ? PTR_W'(oldc) : PTR_W'(MAX_VOTERS);
   assign ptr_lt = ptr_ff < bound;
   assign lim = (16'(limit_ff) > 16'(MAX_VOTERS)) ? 16'(MAX_VOTERS) : 16'(limit_ff);
   assign len = sat_ff ? 32'hFFFF_FFFF : 32'(pos_ff);

   assign sts.need_merge = voter_done && !is_old && ptr_lt;
   assign sts.has_result = voter_done || req_data.final_byte;
   assign sts.merge_again = ptr_lt && (rd_ff < asm_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      bad = (lflags_ff[1] == 1'b0);
      if (h1_ff[39:32] == KIND_JOINT) begin
         bad = bad || (h3_ff != 64'd0) || (oldc == 16'd0) || (lflags_ff[0] == 1'b0)
               || (({1'b0, oldc} + 17'(union_ff)) > {1'b0, lim});
      end else begin
         bad = bad || (h1_ff[39:32] != KIND_FINAL) || (h3_ff == 64'd0) || (oldc != 16'd0);
      end
      if (len < 32'd36) verdict = ST_SHORT;
      else if ((crc_ff ^ 32'hFFFF_FFFF) != td_ff) verdict = ST_CRC;
      else if (!magic_ok_ff || (h1_ff[15:0] != VER_MAJOR)) verdict = ST_MAGIC;
      else if (h1_ff[31:16] != VER_MINOR) verdict = ST_MINOR;
      else if ((h1_ff[63:40] != 24'd0) || sat_ff || (h2_ff != len) || (oldc > lim)
               || (newc == 16'd0) || (newc > lim)
               || ((len - 32'd32) != (32'({total, 3'b000}) + 32'd4)))
         verdict = ST_HEADER;
      else verdict = bad ? ST_SEMANTIC : ST_OK;
   end

   always_comb begin
      out_item = '0;
      if (fin_ff) begin
         out_item.result_kind = RK_VERDICT;
         out_item.status = verdict;
         out_item.command_kind = h1_ff[39:32];
         out_item.joint_log_index = h3_ff;
         out_item.old_list_count = oldc;
         out_item.new_list_count = newc;
      end else begin
         out_item.result_kind = RK_VOTER;
         out_item.voter_id = asm_ff;
         out_item.voter_list = list_ff;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      magic_ok_in = magic_ok_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      h3_in = h3_ff;
      h4_in = h4_ff;
      asm_in = asm_ff;
      prev_in = prev_ff;
      ptr_in = ptr_ff;
      union_in = union_ff;
      crc_in = crc_ff;
      td_in = td_ff;
      lflags_in = lflags_ff;
      sat_in = sat_ff;
      fin_in = fin_ff;
      list_in = list_ff;
      if (cmd.step) begin
         sat_in = sat;
         fin_in = req_data.final_byte;
         list_in = !is_old;
         if (pos_ff >= POS_W'(4)) crc_in = crc_byte(crc_ff, td_ff[7:0]);
         td_in = {b, td_ff[31:8]};
         if (!sat) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff < POS_W'(8)) begin
               if (b != FRAME_MAGIC[pos_ff[2:0]]) magic_ok_in = 1'b0;
            end else if (pos_ff < POS_W'(16)) begin
               h1_in[8*pos_ff[2:0] +: 8] = b;
            end else if (pos_ff < POS_W'(20)) begin
               h2_in[8*pos_ff[1:0] +: 8] = b;
            end else if (pos_ff < POS_W'(28)) begin
               h3_in[8*{~pos_ff[2], pos_ff[1:0]} +: 8] = b;
            end else if (pos_ff < POS_W'(32)) begin
               h4_in[8*pos_ff[1:0] +: 8] = b;
            end else if (region) begin
               if (rel[2:0] == 3'd0) asm_in = {56'd0, b};
               else asm_in[8*rel[2:0] +: 8] = b;
               if (voter_done) begin
                  prev_in = v;
                  if (is_old) begin
                     if ((k == 17'd0) ? (v == 64'd0) : (v <= prev_ff)) lflags_in[0] = 1'b0;
                  end else begin
                     if ((k == {1'b0, oldc}) ? (v == 64'd0) : (v <= prev_ff))
                        lflags_in[1] = 1'b0;
                     if (!ptr_lt && (union_ff != 6'd63)) union_in = union_ff + 6'd1;
                  end
               end
            end
         end
      end
      if (cmd.mcmp) begin
         if (ptr_lt && (rd_ff < asm_ff)) ptr_in = ptr_ff + PTR_W'(1);
         else if (ptr_lt && (rd_ff == asm_ff)) ptr_in = ptr_ff + PTR_W'(1);
         else if (union_ff != 6'd63) union_in = union_ff + 6'd1;
      end
      if (cmd.emit && fin_ff) begin
         pos_in = '0;
         magic_ok_in = 1'b1;
         h1_in = '0;
         h2_in = '0;
         h3_in = '0;
         h4_in = '0;
         asm_in = '0;
         prev_in = '0;
         ptr_in = '0;
         union_in = '0;
         crc_in = 32'hFFFF_FFFF;
         td_in = '0;
         lflags_in = 2'b11;
         sat_in = 1'b0;
         fin_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         pos_ff <= '0;
         magic_ok_ff <= 1'b1;
         h1_ff <= '0;
         h2_ff <= '0;
         h3_ff <= '0;
         h4_ff <= '0;
         asm_ff <= '0;
         prev_ff <= '0;
         ptr_ff <= '0;
         union_ff <= '0;
         crc_ff <= 32'hFFFF_FFFF;
         td_ff <= '0;
         lflags_ff <= 2'b11;
         sat_ff <= 1'b0;
         fin_ff <= 1'b0;
         list_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         pos_ff <= pos_in;
         magic_ok_ff <= magic_ok_in;
         h1_ff <= h1_in;
         h2_ff <= h2_in;
         h3_ff <= h3_in;
         h4_ff <= h4_in;
         asm_ff <= asm_in;
         prev_ff <= prev_in;
         ptr_ff <= ptr_in;
         union_ff <= union_in;
         crc_ff <= crc_in;
         td_ff <= td_in;
         lflags_ff <= lflags_in;
         sat_ff <= sat_in;
         fin_ff <= fin_in;
         list_ff <= list_in;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_data_ff <= out_item;
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[k[IDX_W-1:0]] <= v;
      if (cmd.mread) rd_ff <= store_mem[ptr_ff[IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### rtl/membership_frame_checker.sv
// Membership frame checker top level.
//
// req_ channel: one frame beat per accepted byte, final_byte set on the last.
// rsp_ channel: a voter beat when a voter id completes inside the voter region,
// and one verdict beat at the final byte (a voter closed by that byte is dropped).
// csr_: csr_we writes voter_limit from csr_wdata; write only while the block idles.
// Flow: a byte with no result is taken in the idle state alone. A byte with a
// result passes the emit state to reach the output register, after a read and a
// compare state for each old-store entry compared by the union merge for a new
// voter (entries passed plus one); the merge walk over the single read port of
// the old voter store sets the worst case.
// One byte is in work at a time; the next byte is taken while a finished beat
// waits in the output register.
// A stalled rsp_ holds its beat; a further result waits until it is taken,
// and req_ready stays low meanwhile.
// Reset: synchronous; clears frame state, sets voter_limit to 16, no clearing
// pass over the old voter store. A verdict returns frame state to reset.
module membership_frame_checker
   import mfc_pkg::*;
#(
   parameter int MAX_VOTERS = DEF_MAX_VOTERS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  logic [4:0]      csr_wdata
);

`include "membership_frame_checker_defines.svh"

   cmd_type cmd;
   sts_type sts;

   mfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mfc_datapath #(
      .MAX_VOTERS (MAX_VOTERS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `MFC_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, (!rsp_valid || rsp_ready), "emit over held beat")
   `MFC_ASSERT_NOW(a_cmp_after_read, clock, reset, cmd.mcmp, $past(cmd.mread), "compare without read")
   `MFC_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid, "emitted beat not valid")
   `MFC_ASSERT_NOW(a_ok_newc, clock, reset, (rsp_valid && (rsp_data.result_kind == RK_VERDICT) && (rsp_data.status == ST_OK)), (rsp_data.new_list_count != 16'd0), "ok verdict with empty new list")

endmodule
